@@ src/mask_border_gradient_sum_defines.svh @@
// Assertion macros for the mask border gradient block
`ifndef MASK_BORDER_GRADIENT_SUM_DEFINES_SVH
`define MASK_BORDER_GRADIENT_SUM_DEFINES_SVH

// same-cycle implication
`define MBGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbgs: same-cycle check failed");

// next-cycle implication
`define MBGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbgs: next-cycle check failed");

`endif

@@ src/mbgs_pkg.sv @@
package mbgs_pkg;

    localparam int MAX_BOX_WIDTH = 1024;
    localparam int BOX_HEIGHT_LIMIT = 1024;
    localparam int COL_W = $clog2(MAX_BOX_WIDTH);
    localparam int ROW_W = $clog2(BOX_HEIGHT_LIMIT);

    localparam int GRAY_W = 8;
    localparam int PIX_W = GRAY_W + 1;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int GRAD_W = 30;
    localparam int CNT_W = 22;
    localparam int DELTA_W = GRAY_W + 2;
    localparam int INC_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_WIDTH      = 3'd0,
        CFG_BOX_HEIGHT     = 3'd1,
        CFG_TOUCHES_LEFT   = 3'd2,
        CFG_TOUCHES_RIGHT  = 3'd3,
        CFG_TOUCHES_TOP    = 3'd4,
        CFG_TOUCHES_BOTTOM = 3'd5
    } t_cfg_addr;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] box_width;
        logic [CFG_DATA_W-1:0] box_height;
        logic                  touches_left;
        logic                  touches_right;
        logic                  touches_top;
        logic                  touches_bottom;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] left;
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             has_left;
        logic [INC_W-1:0] edge_cnt;
        logic             last_px;
    } t_s1;

endpackage

@@ src/mbgs_if.sv @@
interface mbgs_pix_if;
    import mbgs_pkg::*;
    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] gray;
    logic              inside_req;
    modport source (output valid, gray, inside_req, input ready);
    modport sink (input valid, gray, inside_req, output ready);
endinterface

interface mbgs_res_if;
    import mbgs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] gradient_total;
    logic [CNT_W-1:0]         border_count;
    modport source (output valid, gradient_total, border_count, input ready);
    modport sink (input valid, gradient_total, border_count, output ready);
endinterface

interface mbgs_cfg_if;
    import mbgs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

@@ src/mask_border_gradient_sum.sv @@
// Mask border gradient sum. Pixels of a component's bounding box arrive in raster
// order, one request per pixel ({inside_req, gray}), taken one per clock unless held.
// The row above lives in a single-port-read, single-port-write line memory of
// MAX_BOX_WIDTH entries: a pixel reads its upper neighbour on acceptance and is
// itself written back when it leaves the pair-test stage, with a bypass for the
// read-after-write case (one-column boxes). The box result is registered after the
// pair-test stage. The input is held only while the last pixel of a box sits in the
// pair-test stage and the previous box result still waits in the output register.
// Box geometry and edge flags must be written through the configuration channel
// (index 0 width, 1 height, 2..5 left/right/top/bottom edge flags) between boxes
// only; the block does not enforce this. No clearing pass is needed after reset.
`include "mask_border_gradient_sum_defines.svh"

module mask_border_gradient_sum
    import mbgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbgs_cfg_if.sink    i_cfg,
    mbgs_pix_if.sink    i_pix,
    mbgs_res_if.source  o_res
);

    t_cfg r_cfg;

    logic [PIX_W-1:0] r_row_mem [MAX_BOX_WIDTH];
    logic [PIX_W-1:0] r_rd;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_pix;

    logic [COL_W-1:0] r_col_idx, n_col_idx;
    logic [ROW_W-1:0] r_row_idx, n_row_idx;
    logic [PIX_W-1:0] r_left;

    logic r_s1_valid;
    t_s1  r_s1, n_s1;

    logic signed [GRAD_W-1:0] r_grad_acc;
    logic [CNT_W-1:0]         r_len_acc;

    logic                     r_out_valid;
    logic signed [GRAD_W-1:0] r_out_grad;
    logic [CNT_W-1:0]         r_out_cnt;

    logic [CFG_DATA_W-1:0] w_eff, h_eff, w_last, h_last;
    logic last_col, last_row, accept, s1_adv;
    logic [PIX_W-1:0] cur, up_pix;
    logic signed [DELTA_W-1:0] d_up, d_left;
    logic [INC_W-1:0] pair_cnt;
    logic signed [GRAD_W-1:0] grad_sum;
    logic [CNT_W-1:0] len_sum;

    function automatic logic signed [DELTA_W-1:0] pair_delta(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic signed [DELTA_W-1:0] ga, gb;
        ga = $signed({2'b00, a[GRAY_W-1:0]});
        gb = $signed({2'b00, b[GRAY_W-1:0]});
        if (a[GRAY_W] == b[GRAY_W]) begin
            return '0;
        end else if (a[GRAY_W]) begin
            return ga - gb;
        end else begin
            return gb - ga;
        end
    endfunction

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_width      <= CFG_DATA_W'(1);
            r_cfg.box_height     <= CFG_DATA_W'(1);
            r_cfg.touches_left   <= 1'b0;
            r_cfg.touches_right  <= 1'b0;
            r_cfg.touches_top    <= 1'b0;
            r_cfg.touches_bottom <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_BOX_WIDTH:      r_cfg.box_width      <= i_cfg.data;
                CFG_BOX_HEIGHT:     r_cfg.box_height     <= i_cfg.data;
                CFG_TOUCHES_LEFT:   r_cfg.touches_left   <= i_cfg.data[0];
                CFG_TOUCHES_RIGHT:  r_cfg.touches_right  <= i_cfg.data[0];
                CFG_TOUCHES_TOP:    r_cfg.touches_top    <= i_cfg.data[0];
                CFG_TOUCHES_BOTTOM: r_cfg.touches_bottom <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // stage 0: position, edge flags, memory read
    always_comb begin
        if (r_cfg.box_width == '0) begin
            w_eff = CFG_DATA_W'(1);
        end else if (r_cfg.box_width > CFG_DATA_W'(MAX_BOX_WIDTH)) begin
            w_eff = CFG_DATA_W'(MAX_BOX_WIDTH);
        end else begin
            w_eff = r_cfg.box_width;
        end
        if (r_cfg.box_height == '0) begin
            h_eff = CFG_DATA_W'(1);
        end else if (r_cfg.box_height > CFG_DATA_W'(BOX_HEIGHT_LIMIT)) begin
            h_eff = CFG_DATA_W'(BOX_HEIGHT_LIMIT);
        end else begin
            h_eff = r_cfg.box_height;
        end
        w_last   = w_eff - CFG_DATA_W'(1);
        h_last   = h_eff - CFG_DATA_W'(1);
        last_col = CFG_DATA_W'(r_col_idx) >= w_last;
        last_row = CFG_DATA_W'(r_row_idx) >= h_last;
        cur      = {i_pix.inside_req, i_pix.gray};

        n_s1.cur      = cur;
        n_s1.left     = r_left;
        n_s1.col      = r_col_idx;
        n_s1.has_up   = r_row_idx != '0;
        n_s1.has_left = r_col_idx != '0;
        n_s1.last_px  = last_col && last_row;
        n_s1.edge_cnt = '0;
        if (i_pix.inside_req) begin
            n_s1.edge_cnt = INC_W'(r_cfg.touches_left && r_col_idx == '0)
                          + INC_W'(r_cfg.touches_right && last_col)
                          + INC_W'(r_cfg.touches_top && r_row_idx == '0)
                          + INC_W'(r_cfg.touches_bottom && last_row);
        end

        n_col_idx = last_col ? '0 : r_col_idx + COL_W'(1);
        if (!last_col) begin
            n_row_idx = r_row_idx;
        end else if (last_row) begin
            n_row_idx = '0;
        end else begin
            n_row_idx = r_row_idx + ROW_W'(1);
        end
    end

    assign s1_adv      = r_s1_valid && (!r_s1.last_px || !r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd      <= r_row_mem[r_col_idx];
            r_fwd_pix <= r_s1.cur;
            r_fwd     <= r_s1_valid && (r_s1.col == r_col_idx);
            r_s1      <= n_s1;
            r_left    <= cur;
        end
        if (s1_adv) begin
            r_row_mem[r_s1.col] <= r_s1.cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx  <= '0;
            r_row_idx  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col_idx <= n_col_idx;
                r_row_idx <= n_row_idx;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage 1: pair tests and accumulation
    always_comb begin
        up_pix   = r_fwd ? r_fwd_pix : r_rd;
        d_up     = r_s1.has_up ? pair_delta(r_s1.cur, up_pix) : '0;
        d_left   = r_s1.has_left ? pair_delta(r_s1.cur, r_s1.left) : '0;
        pair_cnt = INC_W'(r_s1.has_up && (r_s1.cur[GRAY_W] != up_pix[GRAY_W]))
                 + INC_W'(r_s1.has_left && (r_s1.cur[GRAY_W] != r_s1.left[GRAY_W]));
        grad_sum = r_grad_acc + GRAD_W'(d_up) + GRAD_W'(d_left);
        len_sum  = r_len_acc + CNT_W'(pair_cnt) + CNT_W'(r_s1.edge_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_acc  <= '0;
            r_len_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_grad_acc <= r_s1.last_px ? '0 : grad_sum;
                r_len_acc  <= r_s1.last_px ? '0 : len_sum;
            end
            if (s1_adv && r_s1.last_px) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.last_px) begin
            r_out_grad <= grad_sum;
            r_out_cnt  <= len_sum;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.gradient_total = r_out_grad;
    assign o_res.border_count   = r_out_cnt;

    `MBGS_ASSERT_NEXT(a_res_from_last, i_clk, i_rst_n, !r_out_valid && !(s1_adv && r_s1.last_px), !r_out_valid)
    `MBGS_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, s1_adv && r_s1.last_px, r_grad_acc == '0 && r_len_acc == '0)
    `MBGS_ASSERT_NEXT(a_len_step, i_clk, i_rst_n, s1_adv && !r_s1.last_px, (r_len_acc - $past(r_len_acc)) <= CNT_W'(6))
    `MBGS_ASSERT_NOW(a_no_drop, i_clk, i_rst_n, r_s1_valid && r_s1.last_px && r_out_valid && !o_res.ready, !i_pix.ready)

endmodule

@@ tb/mbgs_checker.sv @@
`timescale 1ns / 100ps

module mbgs_checker
    import mbgs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mbgs_cfg_if  i_cfg,
    mbgs_pix_if  i_pix,
    mbgs_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [GRAD_W-1:0] gradient_total;
        logic [CNT_W-1:0]  border_count;
    } t_box_total;

    t_box_total            totals_due[$];
    logic [PIX_W-1:0]      line_above [MAX_BOX_WIDTH];
    logic [PIX_W-1:0]      prev_px;
    int unsigned           col_pos;
    int unsigned           row_pos;
    longint                grad_sum;
    int unsigned           edge_len;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  on_left;
    logic                  on_right;
    logic                  on_top;
    logic                  on_bottom;
    int                    fails;

    assign o_fail_count = fails;

    function automatic void add_pair(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] nb);
        if (px[GRAY_W] != nb[GRAY_W]) begin
            if (px[GRAY_W]) begin
                grad_sum += longint'(px[GRAY_W-1:0]) - longint'(nb[GRAY_W-1:0]);
            end else begin
                grad_sum += longint'(nb[GRAY_W-1:0]) - longint'(px[GRAY_W-1:0]);
            end
            edge_len++;
        end
    endfunction

    always @(posedge i_clk) begin : predict_and_check
        logic [PIX_W-1:0] pixel_word;
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        logic             last_col;
        logic             last_row;
        t_box_total       got;
        t_box_total       want;

        if (!i_rst_n) begin
            totals_due.delete();
            foreach (line_above[k]) line_above[k] = '0;
            prev_px    = '0;
            col_pos    = 0;
            row_pos    = 0;
            grad_sum   = 0;
            edge_len   = 0;
            width_reg  = 1;
            height_reg = 1;
            on_left    = 1'b0;
            on_right   = 1'b0;
            on_top     = 1'b0;
            on_bottom  = 1'b0;
            fails      = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_BOX_WIDTH:      width_reg = i_cfg.data;
                    CFG_BOX_HEIGHT:     height_reg = i_cfg.data;
                    CFG_TOUCHES_LEFT:   on_left = i_cfg.data[0];
                    CFG_TOUCHES_RIGHT:  on_right = i_cfg.data[0];
                    CFG_TOUCHES_TOP:    on_top = i_cfg.data[0];
                    CFG_TOUCHES_BOTTOM: on_bottom = i_cfg.data[0];
                    default: ;
                endcase
            end

            if (i_pix.valid && i_pix.ready) begin
                // out-of-range geometry is clamped
                w = (width_reg == 0) ? 1 :
                    ((width_reg > MAX_BOX_WIDTH) ? MAX_BOX_WIDTH : width_reg);
                h = (height_reg == 0) ? 1 :
                    ((height_reg > BOX_HEIGHT_LIMIT) ? BOX_HEIGHT_LIMIT : height_reg);
                pixel_word = {i_pix.inside_req, i_pix.gray};
                col = col_pos % MAX_BOX_WIDTH;
                last_col = (col_pos >= w - 1);
                last_row = (row_pos >= h - 1);

                if (row_pos > 0) add_pair(pixel_word, line_above[col]);
                if (col_pos > 0) add_pair(pixel_word, prev_px);

                if (pixel_word[GRAY_W]) begin
                    if (on_left && col_pos == 0) edge_len++;
                    if (on_right && last_col) edge_len++;
                    if (on_top && row_pos == 0) edge_len++;
                    if (on_bottom && last_row) edge_len++;
                end

                line_above[col] = pixel_word;
                prev_px = pixel_word;

                if (!last_col) begin
                    col_pos++;
                end else begin
                    col_pos = 0;
                    if (!last_row) begin
                        row_pos++;
                    end else begin
                        want.gradient_total = grad_sum[GRAD_W-1:0];
                        want.border_count = edge_len[CNT_W-1:0];
                        totals_due = {totals_due, want};
                        row_pos  = 0;
                        prev_px  = '0;
                        grad_sum = 0;
                        edge_len = 0;
                    end
                end
            end

            if (i_res.valid && i_res.ready) begin
                got.gradient_total = i_res.gradient_total;
                got.border_count = i_res.border_count;
                if (totals_due.size() == 0) begin
                    fails++;
                    $error("result with no box outstanding: gradient_total %0d, border_count %0d",
                           $signed(got.gradient_total), got.border_count);
                end else begin
                    want = totals_due.pop_front();
                    if (got.gradient_total !== want.gradient_total) begin
                        fails++;
                        $error("gradient_total: expected %0d, got %0d",
                               $signed(want.gradient_total), $signed(got.gradient_total));
                    end
                    if (got.border_count !== want.border_count) begin
                        fails++;
                        $error("border_count: expected %0d, got %0d",
                               want.border_count, got.border_count);
                    end
                end
            end
        end
        o_pending = totals_due.size();
    end

endmodule

@@ tb/tb_mask_border_gradient_sum.sv @@
`timescale 1ns / 100ps

module tb_mask_border_gradient_sum;
    import mbgs_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int PRESSURE_CYCLES = 300;
    localparam int PRESSURE_BOXES  = 30;
    localparam int RANDOM_PIXELS   = 60;
    localparam int RANDOM_BOXES    = 36;

    typedef enum int {
        MASK_NOISE,
        MASK_FULL,
        MASK_EMPTY,
        MASK_BLOB,
        MASK_CHECKER
    } t_mask_shape;

    logic i_clk;
    logic i_rst_n;

    mbgs_cfg_if cfg_bus();
    mbgs_pix_if pix_bus();
    mbgs_res_if res_bus();

    int   fail_count;
    int   boxes_pending;
    logic gaps_on;
    logic pressure_req;
    logic pressure_done;
    int   boxes_sent;
    int   pixels_sent;
    int   box_w;
    int   box_h;

    mask_border_gradient_sum i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    mbgs_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_pix        (pix_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (boxes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int rand_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 85) return $urandom_range(1, 6);
        return $urandom_range(7, 12);
    endfunction

    task automatic send_pixel(input logic [GRAY_W-1:0] g, input logic m);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            pix_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_bus.valid      <= 1'b1;
        pix_bus.gray       <= g;
        pix_bus.inside_req <= m;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= addr;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // flags: {left, right, top, bottom}
    task automatic set_box(input int width, input int height, input logic [3:0] flags);
        write_reg(CFG_BOX_WIDTH, CFG_DATA_W'(width));
        write_reg(CFG_BOX_HEIGHT, CFG_DATA_W'(height));
        write_reg(CFG_TOUCHES_LEFT, CFG_DATA_W'(flags[3]));
        write_reg(CFG_TOUCHES_RIGHT, CFG_DATA_W'(flags[2]));
        write_reg(CFG_TOUCHES_TOP, CFG_DATA_W'(flags[1]));
        write_reg(CFG_TOUCHES_BOTTOM, CFG_DATA_W'(flags[0]));
        box_w = (width == 0) ? 1 : ((width > MAX_BOX_WIDTH) ? MAX_BOX_WIDTH : width);
        box_h = (height == 0) ? 1 : ((height > BOX_HEIGHT_LIMIT) ? BOX_HEIGHT_LIMIT : height);
    endtask

    task automatic send_box(input t_mask_shape shape);
        int                x0;
        int                x1;
        int                y0;
        int                y1;
        int                r;
        logic              m;
        logic [GRAY_W-1:0] g;
        x0 = $urandom_range(0, box_w - 1);
        x1 = $urandom_range(x0, box_w - 1);
        y0 = $urandom_range(0, box_h - 1);
        y1 = $urandom_range(y0, box_h - 1);
        for (int y = 0; y < box_h; y++) begin
            for (int x = 0; x < box_w; x++) begin
                case (shape)
                    MASK_NOISE: m = $urandom_range(0, 1);
                    MASK_FULL:  m = 1'b1;
                    MASK_EMPTY: m = 1'b0;
                    MASK_BLOB:  m = (x >= x0 && x <= x1 && y >= y0 && y <= y1);
                    default:    m = ((x + y) % 2 == 1);
                endcase
                r = $urandom_range(0, 7);
                g = (r == 0) ? 8'h00 : ((r == 1) ? 8'hFF : 8'($urandom));
                send_pixel(g, m);
            end
        end
        boxes_sent++;
    endtask

    // block is idle once every box total is back; allow for the pipeline too
    task automatic settle();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (boxes_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        res_bus.ready = 1'b0;
        pressure_done = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (pressure_req && !pressure_done) begin
                res_bus.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge i_clk);
                pressure_done = 1'b1;
            end
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                res_bus.ready <= 1'b1;
                stall_left = gaps_on ? pick_gap() : 0;
            end
        end
    end

    initial begin : stimulus
        int nbox;
        int target_px;
        int target_box;
        int first_random_box;

        i_rst_n            = 1'b0;
        pix_bus.valid      = 1'b0;
        pix_bus.gray       = '0;
        pix_bus.inside_req = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.addr       = '0;
        cfg_bus.data       = '0;
        gaps_on            = 1'b0;
        pressure_req       = 1'b0;
        boxes_sent         = 0;
        pixels_sent        = 0;
        box_w              = 1;
        box_h              = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: single-pixel box, no image edges
        send_pixel(8'hFF, 1'b1);
        settle();

        // zero geometry clamps to the minimum box; all edge flags count
        set_box(0, 0, 4'b1111);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        settle();

        // writes to unused indices are ignored
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        send_pixel(8'hA5, 1'b1);
        settle();

        set_box(2, 2, 4'b1111);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);
        settle();

        set_box(3, 3, 4'b0000);
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                send_pixel((x == 1 && y == 1) ? 8'hFF : 8'h00, (x == 1 && y == 1));
            end
        end
        settle();

        set_box(4, 1, 4'b1100);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h7F, 1'b1);
        settle();

        // full-width row from an oversize width value
        gaps_on = 1'b1;
        set_box(2047, 1, 4'b1111);
        send_box(MASK_NOISE);
        settle();

        target_px = pixels_sent + RANDOM_PIXELS;
        target_box = boxes_sent + RANDOM_BOXES;
        first_random_box = boxes_sent;
        while (pixels_sent < target_px || boxes_sent < target_box) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (!pressure_req && boxes_sent >= first_random_box + 3) begin
                // tiny boxes back to back while results are held off
                set_box($urandom_range(1, 2), $urandom_range(1, 2), 4'($urandom));
                pressure_req = 1'b1;
                repeat (PRESSURE_BOXES) send_box(t_mask_shape'($urandom_range(0, 4)));
            end else begin
                set_box(rand_extent(), rand_extent(), 4'($urandom));
                nbox = $urandom_range(1, 3);
                repeat (nbox) send_box(t_mask_shape'($urandom_range(0, 4)));
            end
            settle();
        end

        repeat (10) @(negedge i_clk);
        $display("%0d boxes, %0d pixels: 1x1 boxes up to a clamped full-width row, zero geometry,",
                 boxes_sent, pixels_sent);
        $display("edge flag mixes, spare indices and a %0d-cycle result hold-off",
                 PRESSURE_CYCLES);
        if (fail_count == 0 && boxes_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mbgs_pkg.sv
src/mbgs_if.sv
src/mask_border_gradient_sum.sv
tb/mbgs_checker.sv
tb/tb_mask_border_gradient_sum.sv
